@@ hw/rtl/sorted_id_set_defines.svh @@
// Assertion macros for the sorted id set.
`ifndef SORTED_ID_SET_DEFINES_SVH
`define SORTED_ID_SET_DEFINES_SVH

// Flag a condition that must never hold outside reset.
`define SIS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sorted_id_set: forbidden condition seen");

// Check a consequence in the cycle after a trigger.
`define SIS_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("sorted_id_set: expected consequence missing");

`endif

@@ hw/rtl/sis_pkg.sv @@
// Shared constants, codes and link types for the sorted id set.
package sis_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_BITS  = 16;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic               ins_en;
        logic [ID_BITS-1:0] id;
    } cell_ctrl_t;

    typedef struct packed {
        logic [ID_BITS-1:0] entry;
        logic               gt;
    } cell_link_t;

endpackage

@@ hw/rtl/sorted_id_set.sv @@
// Top level of the sorted id set: request decode, occupancy and result register.
// A request is taken on any cycle with start high; busy stays low, so one request
// per cycle is accepted. Its result beat shows one cycle later, marked by done for
// that single cycle, and must be taken then since the receiver cannot stall it.
// Latency and rate are fixed by the row of cells: every slot compares against the
// request id and shifts in the same cycle, so a request completes in one cycle.
`include "sorted_id_set_defines.svh"

module sorted_id_set (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [sis_pkg::ID_BITS-1:0]      item_id,
    output logic                             done,
    output logic                             found,
    output logic [sis_pkg::ID_BITS-1:0]      popped_id,
    output logic [1:0]                       status,
    output logic [sis_pkg::CNT_BITS-1:0]     entry_count
);

    localparam int N  = sis_pkg::CAPACITY;
    localparam int CW = sis_pkg::CNT_BITS;
    localparam int IW = sis_pkg::ID_BITS;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    logic                   found_reg;
    logic                   found_next;
    logic [IW-1:0]          popped_reg;
    logic [IW-1:0]          popped_next;
    sis_pkg::status_t       status_reg;
    sis_pkg::status_t       status_next;

    logic                   accept;
    logic                   hit;
    logic                   full;
    logic                   empty;
    logic                   insert_ok;
    logic                   pop_ok;
    logic [IW-1:0]          top_entry;
    logic                   order_err;

    sis_pkg::cell_ctrl_t    ctrl;
    sis_pkg::cell_link_t    links [N];
    logic [N-1:0]           eq_vec;
    logic [N-1:0]           occ_vec;
    logic [N-1:0]           tail_vec;
    logic [N-1:0]           top_vec;
    logic [N-1:0]           bad_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign hit   = |eq_vec;
    assign full  = (count_reg == CW'(N));
    assign empty = (count_reg == '0);

    assign insert_ok = accept && (req_type == sis_pkg::REQ_INSERT) && !hit && !full;
    assign pop_ok    = accept && (req_type == sis_pkg::REQ_POP) && !empty;

    assign ctrl.ins_en = insert_ok;
    assign ctrl.id     = item_id;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            assign occ_vec[gi]  = (CW'(gi) < count_reg);
            assign tail_vec[gi] = (CW'(gi) == count_reg);
            assign top_vec[gi]  = (CW'(gi + 1) == count_reg);

            if (gi == 0)
            begin : g_first
                sis_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .occupied  (occ_vec[gi]),
                    .at_tail   (tail_vec[gi]),
                    .prev_link ('{entry: '0, gt: 1'b0}),
                    .link      (links[gi]),
                    .eq        (eq_vec[gi])
                );
                assign bad_vec[gi] = 1'b0;
            end
            else
            begin : g_rest
                sis_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .occupied  (occ_vec[gi]),
                    .at_tail   (tail_vec[gi]),
                    .prev_link (links[gi-1]),
                    .link      (links[gi]),
                    .eq        (eq_vec[gi])
                );
                assign bad_vec[gi] = occ_vec[gi] &&
                                     (links[gi-1].entry >= links[gi].entry);
            end
        end
    endgenerate

    assign order_err = |bad_vec;

    always_comb
    begin
        top_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (top_vec[i])
            begin
                top_entry = top_entry | links[i].entry;
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        found_next  = 1'b0;
        popped_next = '0;
        status_next = sis_pkg::ST_OK;
        unique case (req_type)
            sis_pkg::REQ_INSERT:
            begin
                priority if (hit)
                begin
                    status_next = sis_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = sis_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            sis_pkg::REQ_FIND:
            begin
                found_next = hit;
            end
            sis_pkg::REQ_POP:
            begin
                if (empty)
                begin
                    status_next = sis_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    popped_next = top_entry;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!accept)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign popped_id   = popped_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    `SIS_ASSERT_NEVER(a_count_bound, count_reg > CW'(N))
    `SIS_ASSERT_NEVER(a_ascending, order_err)
    `SIS_ASSERT_NEXT(a_insert_grows, insert_ok, count_reg == $past(count_reg) + CW'(1))
    `SIS_ASSERT_NEXT(a_pop_shrinks, pop_ok, count_reg == $past(count_reg) - CW'(1))

endmodule

@@ hw/rtl/sis_cell.sv @@
// One slot of the sorted row: compare against the request id and shift up on insert.
module sis_cell (
    input  logic                         clk,
    input  sis_pkg::cell_ctrl_t          ctrl,
    input  logic                         occupied,
    input  logic                         at_tail,
    input  sis_pkg::cell_link_t          prev_link,
    output sis_pkg::cell_link_t          link,
    output logic                         eq
);

    logic [sis_pkg::ID_BITS-1:0] entry_reg;
    logic [sis_pkg::ID_BITS-1:0] entry_next;
    logic                        gt;

    assign gt = occupied && (entry_reg > ctrl.id);
    assign eq = occupied && (entry_reg == ctrl.id);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            priority if (prev_link.gt)
            begin
                entry_next = prev_link.entry;
            end
            else if (gt || at_tail)
            begin
                entry_next = ctrl.id;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.entry = entry_reg;
    assign link.gt    = gt;

endmodule

@@ dv/sorted_id_set_tb.sv @@
// Testbench for sorted_id_set: directed and random insert/find/pop requests checked against a local set predictor.
`timescale 1ns / 1ps

module sorted_id_set_tb;

    import sis_pkg::*;

    localparam logic [1:0] REQ_NOP    = 2'd3;
    localparam int         RAND_ITEMS = 1750;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         RECENT_MAX = 32;

    typedef struct {
        logic [1:0]         kind;
        logic [ID_BITS-1:0] id;
    } req_beat_t;

    typedef struct {
        logic                found;
        logic [ID_BITS-1:0]  popped_id;
        status_t             status;
        logic [CNT_BITS-1:0] entry_count;
    } set_result_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [1:0]          req_type    = '0;
    logic [ID_BITS-1:0]  item_id     = '0;
    logic                busy;
    logic                done;
    logic                found;
    logic [ID_BITS-1:0]  popped_id;
    logic [1:0]          status;
    logic [CNT_BITS-1:0] entry_count;

    req_beat_t          pending_reqs[$];
    set_result_t        expected_results[$];
    logic [ID_BITS-1:0] recent_ids[$];

    logic [ID_BITS-1:0] held_ids[CAPACITY];
    int                 held_count = 0;

    logic beat_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   idle_cycles = 0;
    int   errors_seen = 0;

    sorted_id_set dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .item_id     (item_id),
        .done        (done),
        .found       (found),
        .popped_id   (popped_id),
        .status      (status),
        .entry_count (entry_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic apply_request(input logic [1:0] kind, input logic [ID_BITS-1:0] id,
                                 output set_result_t res);
        int pos;
        int i;
        bit hit;
        res.found     = 1'b0;
        res.popped_id = '0;
        res.status    = ST_OK;
        hit = 1'b0;
        for (i = 0; i < held_count; i++)
            if (held_ids[i] == id)
                hit = 1'b1;
        case (kind)
            REQ_INSERT:
            begin
                if (hit)
                    res.status = ST_DUP;
                else if (held_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    pos = held_count;
                    while (pos > 0 && held_ids[pos-1] > id)
                    begin
                        held_ids[pos] = held_ids[pos-1];
                        pos--;
                    end
                    held_ids[pos] = id;
                    held_count++;
                end
            end
            REQ_FIND:
                res.found = hit;
            REQ_POP:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    held_count--;
                    res.popped_id = held_ids[held_count];
                end
            end
            default:
                ;
        endcase
        res.entry_count = held_count[CNT_BITS-1:0];
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [ID_BITS-1:0] id);
        req_beat_t b;
        b.kind = kind;
        b.id   = id;
        pending_reqs.push_back(b);
        if (kind == REQ_INSERT)
        begin
            recent_ids.push_back(id);
            if (recent_ids.size() > RECENT_MAX)
                recent_ids.delete(0);
        end
    endtask

    function automatic logic [ID_BITS-1:0] pick_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3 && recent_ids.size() != 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (sel <= 5)
            return ID_BITS'($urandom_range(0, 40));
        else if (sel == 6)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return ID_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] pick_kind(input int p_ins, input int p_find,
                                             input int p_pop);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < p_ins)
            return REQ_INSERT;
        else if (roll < p_ins + p_find)
            return REQ_FIND;
        else if (roll < p_ins + p_find + p_pop)
            return REQ_POP;
        return REQ_NOP;
    endfunction

    // driver: advance the pending queue once a beat is taken
    always @(negedge clk)
    begin
        if (beat_taken)
            pending_reqs.delete(0);
        if (!rst_n || pending_reqs.size() == 0)
        begin
            start    <= 1'b0;
            req_type <= 2'($urandom_range(0, 3));
            item_id  <= ID_BITS'($urandom_range(0, 65535));
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            start    <= 1'b0;
            req_type <= 2'($urandom_range(0, 3));
            item_id  <= ID_BITS'($urandom_range(0, 65535));
        end
        else
        begin
            start    <= 1'b1;
            req_type <= pending_reqs[0].kind;
            item_id  <= pending_reqs[0].id;
            if (burst_left > 1)
                burst_left--;
            else
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // monitor: check the result beat, then predict the beat taken at this edge
    always @(posedge clk)
    begin
        set_result_t want;
        set_result_t nxt;
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors_seen++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0b got %0b", $time, want.found, found);
                        errors_seen++;
                    end
                    if (popped_id !== want.popped_id)
                    begin
                        $display("%0t: popped_id expected %h got %h", $time,
                                 want.popped_id, popped_id);
                        errors_seen++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        errors_seen++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d got %0d", $time,
                                 want.entry_count, entry_count);
                        errors_seen++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_request(req_type, item_id, nxt);
                expected_results.push_back(nxt);
            end
            beat_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sorted_id_set_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int k;
        int made;
        int span;
        int mode;
        logic [1:0] kind;

        queue_req(REQ_POP, 16'h5a5a);
        queue_req(REQ_FIND, 16'h0000);
        queue_req(REQ_NOP, 16'hffff);
        queue_req(REQ_INSERT, 16'hffff);
        queue_req(REQ_INSERT, 16'h0000);
        queue_req(REQ_INSERT, 16'h0000);
        queue_req(REQ_FIND, 16'h0000);
        queue_req(REQ_FIND, 16'hffff);
        queue_req(REQ_FIND, 16'h8000);
        for (k = 14; k >= 1; k--)
            queue_req(REQ_INSERT, ID_BITS'(16'h1000 * k + 16'h0123));
        queue_req(REQ_INSERT, 16'h1234);
        queue_req(REQ_INSERT, 16'hffff);
        queue_req(REQ_POP, 16'h0000);
        queue_req(REQ_INSERT, 16'h7fff);

        made = 0;
        while (made < RAND_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span)
            begin
                case (mode)
                    0: kind = pick_kind(80, 12, 5);
                    1: kind = pick_kind(15, 12, 70);
                    default: kind = pick_kind(40, 30, 25);
                endcase
                queue_req(kind, (kind == REQ_POP) ? ID_BITS'($urandom_range(0, 65535))
                                                  : pick_id());
                if (kind != REQ_NOP)
                    made++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (errors_seen == 0)
            $display("sorted_id_set_tb: clean");
        else
            $display("sorted_id_set_tb: errors");
        $finish;
    end

endmodule
